// ----- rtl/core/sbg_pkg.sv -----
// Shared constants, codes and tables for the stereo baseline geometry block.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
package sbg_pkg;

   localparam int CoordBits   = 21;
   localparam int FieldW      = 21;
   localparam int RegW        = 63;
   localparam int CsrIdxW     = 3;
   localparam int LenW        = 22;
   localparam int AngleW      = 16;
   localparam int RatioW      = 24;
   localparam int CordicSteps = 22;

   localparam logic [RatioW-1:0] RatioMax = '1;
   localparam logic signed [31:0] Angle90  = 32'sd5898240;
   localparam logic signed [31:0] Angle180 = 32'sd11796480;

   localparam logic signed [31:0] AtanTable [CordicSteps] = '{
      32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945, 32'sd234379,
      32'sd117304, 32'sd58666, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667,
      32'sd1833, 32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29,
      32'sd14, 32'sd7, 32'sd4, 32'sd2
   };

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FIRST_CENTER  = 3'd0,
      CSR_SECOND_CENTER = 3'd1,
      CSR_FIRST_AXIS    = 3'd2,
      CSR_SECOND_AXIS   = 3'd3,
      CSR_DEPTH_FLIP    = 3'd4
   } csr_index_type;

endpackage

// ----- rtl/core/sbg_req_if.sv -----
// Request channel of the stereo baseline geometry block.
// Depends on sbg_pkg for field widths.
`timescale 1ns / 1ps
interface sbg_req_if import sbg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     with_point;
   logic signed [FieldW-1:0] point_x;
   logic signed [FieldW-1:0] point_y;
   logic signed [FieldW-1:0] point_z;

   modport source (output valid, with_point, point_x, point_y, point_z, input ready);
   modport sink   (input valid, with_point, point_x, point_y, point_z, output ready);
endinterface

// ----- rtl/core/sbg_rsp_if.sv -----
// Response channel of the stereo baseline geometry block.
// Depends on sbg_pkg for field widths.
`timescale 1ns / 1ps
interface sbg_rsp_if import sbg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              baseline_valid;
   logic [LenW-1:0]   baseline_length;
   logic              angle_valid;
   logic [AngleW-1:0] angle_deg;
   logic              in_front;
   logic [RatioW-1:0] depth_ratio;

   modport source (output valid, baseline_valid, baseline_length, angle_valid, angle_deg,
                    in_front, depth_ratio, input ready);
   modport sink   (input valid, baseline_valid, baseline_length, angle_valid, angle_deg,
                   in_front, depth_ratio, output ready);
endinterface

// ----- rtl/core/stereo_baseline_geometry.sv -----
// Stereo baseline geometry: baseline length, triangulation angle and depth ratio.
// Depends on sbg_pkg, sbg_req_if and sbg_rsp_if.
//
// The block takes one request per clock while not stalled and returns one response per
// request, in order. The longest path is the 32-stage square root of the squared cross
// product followed by the 22-stage CORDIC angle unit; the baseline square root and the
// depth ratio divider run alongside. A full output register with rsp not ready stalls
// the whole pipeline. Camera registers may be written only while no request is in
// flight.
`timescale 1ns / 1ps
module stereo_baseline_geometry import sbg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   sbg_req_if.sink            req_ch,
   sbg_rsp_if.source          rsp_ch,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [RegW-1:0]    csr_wdata
);

   localparam int NumStages  = 63;
   localparam int StgBlFirst = 3;
   localparam int StgBlLast  = StgBlFirst + LenW - 1;
   localparam int StgBlRound = StgBlLast + 1;
   localparam int StgDvPrep  = StgBlRound + 1;
   localparam int StgDvSat   = StgDvPrep + 1;
   localparam int StgDvFirst = StgDvSat + 1;
   localparam int StgDvLast  = StgDvFirst + RatioW - 1;
   localparam int StgCsSum   = 6;
   localparam int StgCsFirst = StgCsSum + 1;
   localparam int StgCsLast  = StgCsFirst + 31;
   localparam int StgCsRound = StgCsLast + 1;
   localparam int StgCoFirst = StgCsRound + 1;
   localparam int StgCoLast  = StgCoFirst + CordicSteps - 1;
   localparam int StgFinal   = StgCoLast + 1;

   typedef struct {
      logic               wp;
      logic signed [21:0] r1 [3];
      logic signed [21:0] r2 [3];
      logic signed [21:0] bd [3];
      logic [43:0]        bsq [3];
      logic [2:0]         sh1;
      logic [2:0]         sh2;
      logic signed [42:0] dp1 [3];
      logic signed [42:0] dp2 [3];
      logic signed [15:0] a [3];
      logic signed [15:0] b [3];
      logic signed [45:0] d1;
      logic signed [45:0] d2;
      logic               nz;
      logic signed [31:0] pdot [3];
      logic signed [31:0] pcr [6];
      logic [46:0]        num;
      logic               front;
      logic signed [32:0] dot;
      logic signed [31:0] cr [3];
      logic [61:0]        csq [3];
      logic [43:0]        bl_rem;
      logic [43:0]        bl_root;
      logic [63:0]        cs_rem;
      logic [63:0]        cs_root;
      logic [LenW-1:0]    len;
      logic [33:0]        den;
      logic [46:0]        dv_rem;
      logic [RatioW-1:0]  quot;
      logic               sat;
      logic signed [61:0] cx;
      logic signed [61:0] cy;
      logic signed [31:0] cz;
      logic               o_bv;
      logic [LenW-1:0]    o_len;
      logic               o_av;
      logic [AngleW-1:0]  o_ang;
      logic               o_front;
      logic [RatioW-1:0]  o_ratio;
   } item_type;

   logic [RegW-1:0] first_center_ff;
   logic [RegW-1:0] second_center_ff;
   logic [RegW-1:0] first_axis_ff;
   logic [RegW-1:0] second_axis_ff;
   logic [1:0]      depth_flip_ff;

   item_type st_ff [NumStages];
   item_type st_in [NumStages];
   item_type entry_in;
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] vld_in;
   logic en;
   logic accept;

   function automatic logic signed [21:0] coord_ext(input logic [FieldW-1:0] f);
      return 22'(signed'(f[CoordBits-1:0]));
   endfunction

   function automatic logic signed [20:0] axis_field(input logic [RegW-1:0] r, input int i);
      return signed'(r[FieldW*i +: FieldW]);
   endfunction

   function automatic logic signed [15:0] shrink(input logic signed [21:0] r,
                                                 input logic [2:0] s);
      logic signed [21:0] mag;
      logic signed [21:0] sv;
      mag = r[21] ? -r : r;
      sv  = mag >>> s;
      return 16'(r[21] ? -sv : sv);
   endfunction

   function automatic logic [2:0] shift_of(input logic signed [21:0] r [3]);
      logic [20:0] m;
      logic [2:0]  s;
      m = '0;
      s = '0;
      for (int i = 0; i < 3; i++) begin
         m = m | 21'(r[i][21] ? -r[i] : r[i]);
      end
      for (int i = 15; i < 21; i++) begin
         if (m[i]) begin
            s = 3'(i - 14);
         end
      end
      return s;
   endfunction

   function automatic item_type stage_fn(input int k, input item_type x);
      item_type           y;
      logic signed [43:0] sq44;
      logic signed [63:0] sq64;
      logic signed [45:0] sd;
      logic [43:0]        bbit;
      logic [63:0]        cbit;
      logic [57:0]        dsh;
      logic [32:0]        rt;
      logic signed [61:0] xi;
      logic signed [61:0] yi;
      logic signed [61:0] dx;
      logic signed [61:0] dy;
      logic signed [31:0] zc;
      logic [31:0]        zr;
      int                 j;
      y = x;
      if (k == 1) begin
         for (int i = 0; i < 3; i++) begin
            sq44     = x.bd[i] * x.bd[i];
            y.bsq[i] = unsigned'(sq44);
            y.dp1[i] = axis_field(first_axis_ff, i) * x.r1[i];
            y.dp2[i] = axis_field(second_axis_ff, i) * x.r2[i];
         end
         y.sh1 = shift_of(x.r1);
         y.sh2 = shift_of(x.r2);
      end
      if (k == 2) begin
         y.bl_rem  = x.bsq[0] + x.bsq[1] + x.bsq[2];
         y.bl_root = '0;
         for (int i = 0; i < 3; i++) begin
            y.a[i] = shrink(x.r1[i], x.sh1);
            y.b[i] = shrink(x.r2[i], x.sh2);
         end
         sd   = 46'(x.dp1[0]) + 46'(x.dp1[1]) + 46'(x.dp1[2]);
         y.d1 = depth_flip_ff[0] ? -sd : sd;
         sd   = 46'(x.dp2[0]) + 46'(x.dp2[1]) + 46'(x.dp2[2]);
         y.d2 = depth_flip_ff[1] ? -sd : sd;
         y.nz = (x.r1[0] | x.r1[1] | x.r1[2]) != '0 && (x.r2[0] | x.r2[1] | x.r2[2]) != '0;
      end
      if (k == 3) begin
         for (int i = 0; i < 3; i++) begin
            y.pdot[i] = x.a[i] * x.b[i];
         end
         y.pcr[0] = x.a[1] * x.b[2];
         y.pcr[1] = x.a[2] * x.b[1];
         y.pcr[2] = x.a[2] * x.b[0];
         y.pcr[3] = x.a[0] * x.b[2];
         y.pcr[4] = x.a[0] * x.b[1];
         y.pcr[5] = x.a[1] * x.b[0];
         y.front  = x.d1 > 0 && x.d2 > 0;
         y.num    = 47'(unsigned'(x.d1)) + 47'(unsigned'(x.d2));
      end
      if (k == 4) begin
         y.dot   = 33'(x.pdot[0]) + 33'(x.pdot[1]) + 33'(x.pdot[2]);
         y.cr[0] = x.pcr[0] - x.pcr[1];
         y.cr[1] = x.pcr[2] - x.pcr[3];
         y.cr[2] = x.pcr[4] - x.pcr[5];
      end
      if (k == 5) begin
         for (int i = 0; i < 3; i++) begin
            sq64     = x.cr[i] * x.cr[i];
            y.csq[i] = sq64[61:0];
         end
      end
      if (k == StgCsSum) begin
         y.cs_rem  = 64'(x.csq[0]) + 64'(x.csq[1]) + 64'(x.csq[2]);
         y.cs_root = '0;
      end
      // digit-by-digit square roots, one result bit per stage
      if (k >= StgBlFirst && k <= StgBlLast) begin
         j    = k - StgBlFirst;
         bbit = 44'(1) << (42 - 2 * j);
         if ({1'b0, x.bl_rem} >= {1'b0, x.bl_root} + {1'b0, bbit}) begin
            y.bl_rem  = x.bl_rem - x.bl_root - bbit;
            y.bl_root = (x.bl_root >> 1) + bbit;
         end else begin
            y.bl_root = x.bl_root >> 1;
         end
      end
      if (k == StgBlRound) begin
         y.len = 22'(x.bl_root + 44'(x.bl_rem > x.bl_root));
      end
      if (k >= StgCsFirst && k <= StgCsLast) begin
         j    = k - StgCsFirst;
         cbit = 64'(1) << (62 - 2 * j);
         if ({1'b0, x.cs_rem} >= {1'b0, x.cs_root} + {1'b0, cbit}) begin
            y.cs_rem  = x.cs_rem - x.cs_root - cbit;
            y.cs_root = (x.cs_root >> 1) + cbit;
         end else begin
            y.cs_root = x.cs_root >> 1;
         end
      end
      // ratio: (num + den/2) / den, restoring, saturating
      if (k == StgDvPrep) begin
         y.den    = {x.len, 12'b0};
         y.dv_rem = x.num + 47'({x.len, 11'b0});
         y.quot   = '0;
      end
      if (k == StgDvSat) begin
         y.sat = 58'(x.dv_rem) >= {x.den, 24'b0};
      end
      if (k >= StgDvFirst && k <= StgDvLast) begin
         j   = StgDvLast - k;
         dsh = 58'(x.den) << j;
         if (58'(x.dv_rem) >= dsh) begin
            y.dv_rem  = x.dv_rem - 47'(dsh);
            y.quot[j] = 1'b1;
         end
      end
      if (k == StgCsRound) begin
         rt = 33'(x.cs_root) + 33'(x.cs_rem > x.cs_root);
         xi = 62'(x.dot) <<< 24;
         yi = signed'({5'b0, rt, 24'b0});
         if (xi < 0) begin
            y.cx = yi;
            y.cy = -xi;
            y.cz = Angle90;
         end else begin
            y.cx = xi;
            y.cy = yi;
            y.cz = '0;
         end
      end
      if (k >= StgCoFirst && k <= StgCoLast) begin
         j  = k - StgCoFirst;
         dx = x.cy >>> j;
         dy = x.cx >>> j;
         if (x.cy > 0) begin
            y.cx = x.cx + dx;
            y.cy = x.cy - dy;
            y.cz = x.cz + AtanTable[j];
         end else if (x.cy < 0) begin
            y.cx = x.cx - dx;
            y.cy = x.cy + dy;
            y.cz = x.cz - AtanTable[j];
         end
      end
      if (k == StgFinal) begin
         zc = x.cz < 0 ? 32'sd0 : (x.cz > Angle180 ? Angle180 : x.cz);
         zr = (unsigned'(zc) + 32'd128) >> 8;
         y.o_bv    = x.len != '0;
         y.o_len   = y.o_bv ? x.len : '0;
         y.o_av    = y.o_bv && x.wp && x.nz;
         y.o_ang   = y.o_av ? zr[AngleW-1:0] : '0;
         y.o_front = y.o_av && x.front;
         y.o_ratio = y.o_front ? (x.sat ? RatioMax : x.quot) : '0;
      end
      return y;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         first_center_ff  <= '0;
         second_center_ff <= '0;
         first_axis_ff    <= '0;
         second_axis_ff   <= '0;
         depth_flip_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIRST_CENTER:  first_center_ff  <= csr_wdata;
            CSR_SECOND_CENTER: second_center_ff <= csr_wdata;
            CSR_FIRST_AXIS:    first_axis_ff    <= csr_wdata;
            CSR_SECOND_AXIS:   second_axis_ff   <= csr_wdata;
            CSR_DEPTH_FLIP:    depth_flip_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign en           = !vld_ff[NumStages-1] || rsp_ch.ready;
   assign req_ch.ready = en && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign vld_in       = {vld_ff[NumStages-2:0], accept};

   always_comb begin
      logic signed [21:0] p;
      logic signed [21:0] c1;
      logic signed [21:0] c2;
      entry_in    = '{default: '0};
      entry_in.wp = req_ch.with_point;
      for (int i = 0; i < 3; i++) begin
         p  = coord_ext(i == 0 ? req_ch.point_x : (i == 1 ? req_ch.point_y : req_ch.point_z));
         c1 = coord_ext(first_center_ff[FieldW*i +: FieldW]);
         c2 = coord_ext(second_center_ff[FieldW*i +: FieldW]);
         entry_in.r1[i] = p - c1;
         entry_in.r2[i] = p - c2;
         entry_in.bd[i] = c1 - c2;
      end
   end

   assign st_in[0] = entry_in;

   for (genvar g = 1; g < NumStages; g++) begin : g_stage
      assign st_in[g] = stage_fn(g, st_ff[g-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NumStages; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign rsp_ch.valid           = vld_ff[NumStages-1];
   assign rsp_ch.baseline_valid  = st_ff[NumStages-1].o_bv;
   assign rsp_ch.baseline_length = st_ff[NumStages-1].o_len;
   assign rsp_ch.angle_valid     = st_ff[NumStages-1].o_av;
   assign rsp_ch.angle_deg       = st_ff[NumStages-1].o_ang;
   assign rsp_ch.in_front        = st_ff[NumStages-1].o_front;
   assign rsp_ch.depth_ratio     = st_ff[NumStages-1].o_ratio;

`ifndef SYNTHESIS
   a_no_baseline: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.baseline_valid |->
         rsp_ch.baseline_length == '0 && !rsp_ch.angle_valid && !rsp_ch.in_front)
      else $error("fields set without a baseline");
   a_no_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.angle_valid |->
         rsp_ch.angle_deg == '0 && !rsp_ch.in_front && rsp_ch.depth_ratio == '0)
      else $error("point fields set without an angle");
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.angle_deg <= 16'd46080)
      else $error("angle beyond 180 degrees");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");
   a_enter: assert property (@(posedge clock) disable iff (reset)
      accept |=> vld_ff[0])
      else $error("accepted request lost at entry");
`endif

endmodule

// ----- test/tb_stereo_baseline_geometry.sv -----
// Self-checking testbench for stereo_baseline_geometry: drives random and directed
// requests, predicts each response in a scoreboard class. Depends on sbg_pkg and the
// sbg_req_if / sbg_rsp_if interfaces.
`timescale 1ns / 1ps
module tb_stereo_baseline_geometry;
   import sbg_pkg::*;

   typedef struct packed {
      bit              baseline_valid;
      bit [LenW-1:0]   baseline_length;
      bit              angle_valid;
      bit [AngleW-1:0] angle_deg;
      bit              in_front;
      bit [RatioW-1:0] depth_ratio;
   } geom_result_type;

   class geometry_scoreboard;
      bit [RegW-1:0] center_a, center_b, axis_a, axis_b;
      bit [1:0] flip;
      geom_result_type pending[$];
      int mismatches;

      function longint sx21(bit [20:0] v);
         return longint'(signed'(v));
      endfunction

      function longint unsigned root_round(longint unsigned s);
         longint unsigned r, b, rem;
         r = 0; b = 64'd1 << 62; rem = s;
         while (b > rem) b >>= 2;
         while (b != 0) begin
            if (rem >= r + b) begin
               rem -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return (rem > r) ? r + 1 : r;
      endfunction

      function longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      function void reduce(ref longint r[3]);
         longint m, a;
         int s;
         m = 0; s = 0;
         for (int k = 0; k < 3; k++) begin
            a = r[k] < 0 ? -r[k] : r[k];
            if (a > m) m = a;
         end
         while ((m >> s) >= 32768) s++;
         for (int k = 0; k < 3; k++) r[k] = r[k] >= 0 ? (r[k] >> s) : -((-r[k]) >> s);
      endfunction

      function longint unsigned ray_angle(longint a[3], longint b[3]);
         longint dot, c0, c1, c2, x, y, z, t, dx, dy;
         longint unsigned cs;
         reduce(a);
         reduce(b);
         dot = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
         c0 = a[1]*b[2] - a[2]*b[1];
         c1 = a[2]*b[0] - a[0]*b[2];
         c2 = a[0]*b[1] - a[1]*b[0];
         cs = c0*c0 + c1*c1 + c2*c2;
         x = dot * 16777216;
         y = longint'(root_round(cs)) * 16777216;
         z = 0;
         if (x < 0) begin
            t = x; x = y; y = -t; z = Angle90;
         end
         for (int i = 0; i < CordicSteps; i++) begin
            dx = floor_shift(y, i); dy = floor_shift(x, i);
            if (y > 0) begin
               x += dx; y -= dy; z += AtanTable[i];
            end else if (y < 0) begin
               x -= dx; y += dy; z -= AtanTable[i];
            end
         end
         if (z < 0) z = 0;
         if (z > Angle180) z = Angle180;
         return (unsigned'(z) + 128) >> 8;
      endfunction

      function void note_request(bit wp, bit [20:0] px, bit [20:0] py, bit [20:0] pz);
         geom_result_type e;
         longint ca[3], cb[3], xa[3], xb[3], p[3], ra[3], rb[3], d, d1, d2;
         longint unsigned s, len, num, den, q;
         e = '{default: 0};
         s = 0;
         for (int k = 0; k < 3; k++) begin
            ca[k] = sx21(center_a[21*k +: 21]);
            cb[k] = sx21(center_b[21*k +: 21]);
            xa[k] = sx21(axis_a[21*k +: 21]);
            xb[k] = sx21(axis_b[21*k +: 21]);
            d = ca[k] - cb[k];
            s += d * d;
         end
         p[0] = sx21(px); p[1] = sx21(py); p[2] = sx21(pz);
         if (s != 0) begin
            len = root_round(s);
            e.baseline_valid = 1;
            e.baseline_length = len[LenW-1:0];
            for (int k = 0; k < 3; k++) begin
               ra[k] = p[k] - ca[k];
               rb[k] = p[k] - cb[k];
            end
            if (wp && (ra[0] | ra[1] | ra[2]) != 0 && (rb[0] | rb[1] | rb[2]) != 0) begin
               e.angle_valid = 1;
               e.angle_deg = AngleW'(ray_angle(ra, rb));
               d1 = xa[0]*ra[0] + xa[1]*ra[1] + xa[2]*ra[2];
               d2 = xb[0]*rb[0] + xb[1]*rb[1] + xb[2]*rb[2];
               if (flip[0]) d1 = -d1;
               if (flip[1]) d2 = -d2;
               if (d1 > 0 && d2 > 0) begin
                  num = d1 + d2;
                  den = len << 12;
                  q = (num + (den >> 1)) / den;
                  e.in_front = 1;
                  e.depth_ratio = q > RatioMax ? RatioMax : q[RatioW-1:0];
               end
            end
         end
         pending.push_back(e);
      endfunction

      function void check_response(geom_result_type got);
         geom_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with no request pending");
            return;
         end
         e = pending.pop_front();
         if (got != e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp bv=%0d len=%0d av=%0d ang=%0d fr=%0d rat=%0d ",
                  e.baseline_valid, e.baseline_length, e.angle_valid, e.angle_deg,
                  e.in_front, e.depth_ratio,
                  " act bv=%0d len=%0d av=%0d ang=%0d fr=%0d rat=%0d",
                  got.baseline_valid, got.baseline_length,
                  got.angle_valid, got.angle_deg, got.in_front, got.depth_ratio);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [RegW-1:0] csr_wdata = '0;
   sbg_req_if req_ch ();
   sbg_rsp_if rsp_ch ();
   geometry_scoreboard sb = new();
   bit quiet;
   longint cycles;

   stereo_baseline_geometry uut (.clock, .reset, .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source), .csr_we, .csr_index, .csr_wdata);

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 0; req_ch.with_point = 0;
      req_ch.point_x = 0; req_ch.point_y = 0; req_ch.point_z = 0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // response side: random stall bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response('{rsp_ch.baseline_valid, rsp_ch.baseline_length,
            rsp_ch.angle_valid, rsp_ch.angle_deg, rsp_ch.in_front, rsp_ch.depth_ratio});
      if (quiet || reset) begin
         rsp_ch.ready <= !reset;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= 1;
      end
   end

   task automatic csr_write(csr_index_type idx, bit [RegW-1:0] v);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      if (idx == CSR_FIRST_CENTER) sb.center_a = v;
      if (idx == CSR_SECOND_CENTER) sb.center_b = v;
      if (idx == CSR_FIRST_AXIS) sb.axis_a = v;
      if (idx == CSR_SECOND_AXIS) sb.axis_b = v;
      if (idx == CSR_DEPTH_FLIP) sb.flip = v[1:0];
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic send(bit wp, bit [20:0] px, bit [20:0] py, bit [20:0] pz);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid <= 1; req_ch.with_point <= wp;
      req_ch.point_x <= px; req_ch.point_y <= py; req_ch.point_z <= pz;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(wp, px, py, pz);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic bit [20:0] rnd_coord(int mode);
      case (mode)
         0: return 21'($urandom);
         1: return 21'($urandom_range(0, 4095) - 2048);
         default: return 21'($urandom_range(0, 255) - 128);
      endcase
   endfunction

   function automatic bit [RegW-1:0] rnd_pack(int mode);
      return {rnd_coord(mode), rnd_coord(mode), rnd_coord(mode)};
   endfunction

   function automatic bit [RegW-1:0] rnd_axis();
      bit [RegW-1:0] v;
      v = '0;
      v[21*$urandom_range(0, 2) +: 21] = $urandom_range(0, 1) ? 21'h80000 : 21'h180000;
      return $urandom_range(0, 3) == 0 ? RegW'({$urandom, $urandom}) : v;
   endfunction

   initial begin
      bit [20:0] mx, mn;
      int mode;
      mx = 21'h0FFFFF; mn = 21'h100000;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // coincident centers after reset
      send(1, 5, 6, 7);
      send(0, 0, 0, 0);
      drain();
      csr_write(CSR_FIRST_CENTER, {21'd0, 21'd0, 21'd0});
      csr_write(CSR_SECOND_CENTER, {21'd0, 21'd0, 21'd1024});
      csr_write(CSR_FIRST_AXIS, {21'h80000, 21'd0, 21'd0});
      csr_write(CSR_SECOND_AXIS, {21'h80000, 21'd0, 21'd0});
      csr_write(CSR_DEPTH_FLIP, 0);
      send(0, 1, 2, 3);
      send(1, 512, 0, 4096);
      send(1, 0, 0, 0);
      send(1, 1024, 0, 0);
      send(1, 512, 0, 21'h1FF000);
      send(1, mx, mx, mx);
      send(1, mn, mn, mn);
      send(1, mx, mn, mx);
      send(1, 2048, 0, 0);
      send(1, 21'h1FFC00, 0, 0);
      drain();
      csr_write(CSR_DEPTH_FLIP, 3);
      send(1, 512, 0, 21'h1FF000);
      send(1, 512, 7, 4096);
      drain();
      csr_write(CSR_FIRST_CENTER, {mn, mn, mn});
      csr_write(CSR_SECOND_CENTER, {mx, mx, mx});
      csr_write(CSR_DEPTH_FLIP, 1);
      send(1, 0, 0, 0);
      send(1, mx, mx, mx);
      send(1, 0, 0, 1);
      send(1, mn, 0, mx);
      drain();
      for (int ph = 0; ph < 24; ph++) begin
         mode = ph % 3;
         csr_write(CSR_FIRST_CENTER, rnd_pack(mode));
         csr_write(CSR_SECOND_CENTER, ph == 5 ? sb.center_a : rnd_pack(mode));
         csr_write(CSR_FIRST_AXIS, rnd_axis());
         csr_write(CSR_SECOND_AXIS, rnd_axis());
         csr_write(CSR_DEPTH_FLIP, $urandom_range(0, 3));
         if (ph >= 21) quiet = 1;
         for (int n = 0; n < 75; n++) begin
            case ($urandom_range(0, 9))
               0: send(0, rnd_coord(0), rnd_coord(0), rnd_coord(0));
               1: send(1, sb.center_a[20:0], sb.center_a[41:21], sb.center_a[62:42]);
               2: send(1, rnd_coord(0), rnd_coord(0), rnd_coord(0));
               default: send(1, rnd_coord(mode), rnd_coord(mode), rnd_coord(mode));
            endcase
         end
         drain();
      end
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
